// ===== rtl/core/sab_pkg.sv =====
`timescale 1ns / 1ps
package sab_pkg;

    // screen limits for coverage
    localparam int SCREEN_WIDTH  = 536;
    localparam int SCREEN_HEIGHT = 240;

    // texel memory address width, depth is 2**SRC_ADDR_W
    localparam int SRC_ADDR_W = 18;

    // datapath widths fixed by the field widths
    localparam int LOC_W  = 10;  // offset inside destination rectangle
    localparam int SRC_W  = 11;  // source width/height
    localparam int DST_W  = 10;  // destination width/height
    localparam int PROD_W = 21;  // offset times source size
    localparam int QUO_W  = 11;  // source coordinate
    localparam int CRD_W  = 12;  // signed screen coordinate math

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic {
        FUNC_LOAD    = 1'b0,
        FUNC_COMPOSE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        REG_DEST_X        = 3'd0,
        REG_DEST_Y        = 3'd1,
        REG_DEST_WIDTH    = 3'd2,
        REG_DEST_HEIGHT   = 3'd3,
        REG_SOURCE_WIDTH  = 3'd4,
        REG_SOURCE_HEIGHT = 3'd5,
        REG_FLIP_VERTICAL = 3'd6
    } t_reg_idx;

    // exact x / 255 for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

endpackage

// ===== rtl/core/scaled_alpha_blit.sv =====
`timescale 1ns / 1ps
// throughput: one transaction per cycle while the pipeline advances, loads and composes mixed freely
// the pipeline advances whenever the output register is empty or taken
// texel writes happen in pipeline order at the memory stage
// reset (synchronous, active low) clears config and all valid bits; texels stay
module scaled_alpha_blit #(
    parameter int ADDR_W = sab_pkg::SRC_ADDR_W
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [17:0] i_texel_index,
    input  logic [31:0] i_texel_value,
    input  logic [9:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic [31:0] i_dst_pixel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pixel_out,
    output logic        o_covered,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data
);
    import sab_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    typedef struct packed {
        logic              func;
        logic              cov;
        logic [31:0]       data;
        logic [ADDR_W-1:0] addr;
    } t_side;

    // config registers
    logic signed [10:0] r_dx, r_dy;
    logic [DST_W-1:0]   r_dw, r_dh;
    logic [SRC_W-1:0]   r_sw, r_sh;
    logic               r_flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx   <= '0;
            r_dy   <= '0;
            r_dw   <= '0;
            r_dh   <= '0;
            r_sw   <= '0;
            r_sh   <= '0;
            r_flip <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DEST_X:        r_dx   <= i_cfg_data;
                REG_DEST_Y:        r_dy   <= i_cfg_data;
                REG_DEST_WIDTH:    r_dw   <= i_cfg_data[DST_W-1:0];
                REG_DEST_HEIGHT:   r_dh   <= i_cfg_data[DST_W-1:0];
                REG_SOURCE_WIDTH:  r_sw   <= i_cfg_data;
                REG_SOURCE_HEIGHT: r_sh   <= i_cfg_data;
                REG_FLIP_VERTICAL: r_flip <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // global advance
    logic w_en;
    logic r_out_vld;
    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    // stage 1: coverage test and offsets
    logic signed [CRD_W-1:0] w_px, w_py, w_xend, w_yend;
    logic                    w_cov;
    t_side                   n1_sd;
    logic [LOC_W-1:0]        n1_lx, n1_ly;

    always_comb begin
        w_px   = signed'({2'b00, i_pixel_x});
        w_py   = signed'({4'b0000, i_pixel_y});
        w_xend = CRD_W'(r_dx) + signed'(CRD_W'(r_dw));
        w_yend = CRD_W'(r_dy) + signed'(CRD_W'(r_dh));
        w_cov  = (r_dw != '0) && (r_dh != '0)
              && (w_px >= CRD_W'(r_dx)) && (w_px < w_xend)
              && (w_py >= CRD_W'(r_dy)) && (w_py < w_yend)
              && ({2'b00, i_pixel_x} < CRD_W'(SCREEN_WIDTH))
              && ({4'b0000, i_pixel_y} < CRD_W'(SCREEN_HEIGHT));
        n1_lx  = LOC_W'(w_px - CRD_W'(r_dx));
        n1_ly  = LOC_W'(w_py - CRD_W'(r_dy));
        n1_sd.func = i_func;
        n1_sd.cov  = w_cov;
        n1_sd.data = (t_func'(i_func) == FUNC_LOAD) ? i_texel_value : i_dst_pixel;
        n1_sd.addr = ADDR_W'(i_texel_index);
    end

    logic             r1_vld;
    t_side            r1_sd;
    logic [LOC_W-1:0] r1_lx, r1_ly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sd <= n1_sd;
            r1_lx <= n1_lx;
            r1_ly <= n1_ly;
        end
    end

    // stage 2: scale offsets by source size
    logic              r2_vld;
    t_side             r2_sd;
    logic [PROD_W-1:0] r2_nx, r2_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sd <= r1_sd;
            r2_nx <= PROD_W'(r1_lx) * PROD_W'(r_sw);
            r2_ny <= PROD_W'(r1_ly) * PROD_W'(r_sh);
        end
    end

    // divide stages: source coordinates
    logic [QUO_W-1:0] w_qx, w_qy;

    sab_div #(.NUM_W(PROD_W), .DEN_W(DST_W), .QUO_W(QUO_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r2_nx),
        .i_den (r_dw),
        .o_quo (w_qx)
    );

    sab_div #(.NUM_W(PROD_W), .DEN_W(DST_W), .QUO_W(QUO_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r2_ny),
        .i_den (r_dh),
        .o_quo (w_qy)
    );

    // side data riding along the divider
    logic  r_dvld [QUO_W];
    t_side r_dsd  [QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) r_dvld[k] <= 1'b0;
        end else if (w_en) begin
            r_dvld[0] <= r2_vld;
            for (int k = 1; k < QUO_W; k++) r_dvld[k] <= r_dvld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dsd[0] <= r2_sd;
            for (int k = 1; k < QUO_W; k++) r_dsd[k] <= r_dsd[k-1];
        end
    end

    // stage 3: row flip and texel address, wrapping at memory depth
    logic [ADDR_W-1:0] w_sy;
    t_side             n3_sd;

    always_comb begin
        w_sy  = r_flip ? (ADDR_W'(r_sh) - ADDR_W'(1) - ADDR_W'(w_qy)) : ADDR_W'(w_qy);
        n3_sd = r_dsd[QUO_W-1];
        if (t_func'(r_dsd[QUO_W-1].func) == FUNC_COMPOSE) begin
            n3_sd.addr = ADDR_W'(w_sy * ADDR_W'(r_sw)) + ADDR_W'(w_qx);
        end
    end

    logic  r3_vld;
    t_side r3_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r_dvld[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sd <= n3_sd;
        end
    end

    // stage 4: texel memory, load writes or compose reads
    logic [31:0] r_mem [DEPTH];
    logic        r4_vld;
    t_side       r4_sd;
    logic [31:0] r4_tex;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r3_vld && t_func'(r3_sd.func) == FUNC_LOAD) begin
                r_mem[r3_sd.addr] <= r3_sd.data;
            end else begin
                r4_tex <= r_mem[r3_sd.addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sd <= r3_sd;
        end
    end

    // stage 5: weighted channel sums
    logic [7:0]  w_alpha;
    logic [15:0] n5_sum [3];

    always_comb begin
        w_alpha = r4_tex[31:24];
        for (int c = 0; c < 3; c++) begin
            n5_sum[c] = 16'(r4_tex[8*c +: 8]) * 16'(w_alpha)
                      + 16'(r4_sd.data[8*c +: 8]) * 16'(ALPHA_OPAQUE - w_alpha);
        end
    end

    logic        r5_vld;
    logic        r5_cov;
    logic [31:0] r5_dst;
    logic [31:0] r5_tex;
    logic [15:0] r5_sum [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld && t_func'(r4_sd.func) == FUNC_COMPOSE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_cov <= r4_sd.cov;
            r5_dst <= r4_sd.data;
            r5_tex <= r4_tex;
            for (int c = 0; c < 3; c++) r5_sum[c] <= n5_sum[c];
        end
    end

    // stage 6: normalize and select, output register
    logic [31:0] n_pix;

    always_comb begin
        if (!r5_cov || r5_tex[31:24] == ALPHA_CLEAR) begin
            n_pix = r5_dst;
        end else if (r5_tex[31:24] == ALPHA_OPAQUE) begin
            n_pix = {ALPHA_OPAQUE, r5_tex[23:0]};
        end else begin
            n_pix = {ALPHA_OPAQUE, div255(r5_sum[2]), div255(r5_sum[1]), div255(r5_sum[0])};
        end
    end

    logic [31:0] r_out_pix;
    logic        r_out_cov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pix <= n_pix;
            r_out_cov <= r5_cov;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_pixel_out = r_out_pix;
    assign o_covered   = r_out_cov;

    // a stalled output freezes the address stage
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> ($stable(r3_sd) && $stable(r3_vld)))
        else $error("address stage moved during output stall");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // a load never turns into a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r4_vld && t_func'(r4_sd.func) == FUNC_LOAD) |=> !r5_vld)
        else $error("load produced a result");

endmodule

// ===== rtl/core/sab_div.sv =====
`timescale 1ns / 1ps
module sab_div #(
    parameter int NUM_W = sab_pkg::PROD_W,
    parameter int DEN_W = sab_pkg::DST_W,
    parameter int QUO_W = sab_pkg::QUO_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    import sab_pkg::*;

    // one quotient bit per stage, most significant first
    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            localparam int B = QUO_W - 1 - k;
            logic [NUM_W-1:0] w_rin;
            logic [QUO_W-1:0] w_qin;
            logic [NUM_W:0]   w_trial;
            logic             w_ge;
            logic [NUM_W-1:0] n_rem;
            logic [QUO_W-1:0] n_quo;

            if (k == 0) begin : g_first
                assign w_rin = i_num;
                assign w_qin = '0;
            end else begin : g_next
                assign w_rin = r_rem[k-1];
                assign w_qin = r_quo[k-1];
            end

            // trial subtract of the shifted divisor
            always_comb begin
                w_trial = (NUM_W+1)'(i_den) << B;
                w_ge    = {1'b0, w_rin} >= w_trial;
                n_rem   = w_ge ? NUM_W'({1'b0, w_rin} - w_trial) : w_rin;
                n_quo   = w_qin | (QUO_W'(w_ge) << B);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_quo[k] <= n_quo;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ===== bench/tb_scaled_alpha_blit.sv =====
`timescale 1ns / 1ps
module tb_scaled_alpha_blit;
    import sab_pkg::*;

    localparam int TEXEL_DEPTH = 1 << SRC_ADDR_W;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        t_func       func;
        logic [17:0] index;
        logic [31:0] value;
        logic [9:0]  px;
        logic [7:0]  py;
        logic [31:0] dpix;
    } blit_op_t;

    typedef struct {
        logic [31:0] pixel;
        logic        covered;
    } pixel_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_func;
    logic [17:0] i_texel_index;
    logic [31:0] i_texel_value;
    logic [9:0]  i_pixel_x;
    logic [7:0]  i_pixel_y;
    logic [31:0] i_dst_pixel;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_pixel_out;
    logic        o_covered;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [10:0] i_cfg_data;

    scaled_alpha_blit dut (.*);

    // predictor state: configuration copy and texel store
    int          cur_dx, cur_dy, cur_dw, cur_dh, cur_sw, cur_sh;
    bit          cur_flip;
    logic [31:0] texel_store [int];
    bit          texel_loaded [TEXEL_DEPTH];

    blit_op_t      op_queue[$];
    pixel_result_t pixel_expect_q[$];
    int            err_count;
    int            cycle_count;
    bit            quiet_mode;
    int            send_idle, recv_idle;
    bit            took_op;

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // destination coverage and wrapped texel address for one pixel
    function automatic bit map_pixel(input int px, input int py, output int addr);
        int     lx, ly, sx, sy;
        longint a;
        addr = 0;
        if (cur_dw == 0 || cur_dh == 0 || px < cur_dx || px >= cur_dx + cur_dw ||
            py < cur_dy || py >= cur_dy + cur_dh ||
            px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)
            return 1'b0;
        lx = px - cur_dx;
        ly = py - cur_dy;
        sx = (lx * cur_sw) / cur_dw;
        sy = (ly * cur_sh) / cur_dh;
        if (cur_flip) sy = cur_sh - 1 - sy;
        a = longint'(sy) * cur_sw + sx;
        a = a % TEXEL_DEPTH;
        if (a < 0) a += TEXEL_DEPTH;
        addr = int'(a);
        return 1'b1;
    endfunction

    // bgra blend, alpha forced opaque unless texel is clear
    function automatic logic [31:0] blend_bgra(input logic [31:0] t, input logic [31:0] d);
        logic [31:0] res;
        int          a, tc, dc;
        a = t[31:24];
        if (a == 0) return d;
        if (a == 255) return {ALPHA_OPAQUE, t[23:0]};
        res = {ALPHA_OPAQUE, 24'h0};
        for (int sh = 0; sh < 24; sh += 8) begin
            tc = (t >> sh) & 8'hFF;
            dc = (d >> sh) & 8'hFF;
            res[sh +: 8] = 8'((tc * a + dc * (255 - a)) / 255);
        end
        return res;
    endfunction

    // work out the result of one accepted transaction
    task automatic predict_blit(input blit_op_t op);
        int            addr;
        pixel_result_t r;
        logic [31:0]   t;
        if (op.func == FUNC_LOAD) begin
            texel_store[int'(op.index)] = op.value;
            return;
        end
        r.covered = map_pixel(op.px, op.py, addr);
        if (r.covered) begin
            t = texel_store.exists(addr) ? texel_store[addr] : 32'h0;
            r.pixel = blend_bgra(t, op.dpix);
        end else begin
            r.pixel = op.dpix;
        end
        pixel_expect_q.push_back(r);
    endtask

    task automatic queue_load(input int index, input logic [31:0] value);
        blit_op_t op;
        op.func = FUNC_LOAD;
        op.index = 18'(index);
        op.value = value;
        op.px = 10'($urandom);
        op.py = 8'($urandom);
        op.dpix = $urandom;
        texel_loaded[index] = 1'b1;
        op_queue.push_back(op);
    endtask

    function automatic logic [31:0] rand_texel();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: v[31:24] = ALPHA_CLEAR;
            1: v[31:24] = ALPHA_OPAQUE;
            default: ;
        endcase
        return v;
    endfunction

    // compose op; loads the texel it reads first if it was never written
    task automatic queue_compose(input int px, input int py, input logic [31:0] dpix);
        blit_op_t op;
        int       addr;
        if (map_pixel(px, py, addr) && !texel_loaded[addr])
            queue_load(addr, rand_texel());
        op.func = FUNC_COMPOSE;
        op.index = 18'($urandom);
        op.value = $urandom;
        op.px = 10'(px);
        op.py = 8'(py);
        op.dpix = dpix;
        op_queue.push_back(op);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 11'(value);
        case (idx)
            REG_DEST_X:        cur_dx = value;
            REG_DEST_Y:        cur_dy = value;
            REG_DEST_WIDTH:    cur_dw = value;
            REG_DEST_HEIGHT:   cur_dh = value;
            REG_SOURCE_WIDTH:  cur_sw = value;
            REG_SOURCE_HEIGHT: cur_sh = value;
            default:           cur_flip = value[0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_blit(input int dx, input int dy, input int dw, input int dh,
                            input int sw, input int sh, input int flip);
        write_reg(REG_DEST_X, dx);
        write_reg(REG_DEST_Y, dy);
        write_reg(REG_DEST_WIDTH, dw);
        write_reg(REG_DEST_HEIGHT, dh);
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_FLIP_VERTICAL, flip);
    endtask

    // wait until every transaction is sent and every result has come
    task automatic wait_idle();
        while (op_queue.size() != 0 || i_valid || pixel_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_ops(input int count);
        int px, py;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 2) begin
                queue_load($urandom_range(0, TEXEL_DEPTH - 1), rand_texel());
            end else begin
                px = $urandom_range(0, SCREEN_WIDTH - 1);
                py = $urandom_range(0, SCREEN_HEIGHT - 1);
                if ($urandom_range(0, 9) < 8 && cur_dw > 0 && cur_dh > 0) begin
                    px = cur_dx + $urandom_range(0, cur_dw - 1);
                    py = cur_dy + $urandom_range(0, cur_dh - 1);
                    if (px < 0 || px >= SCREEN_WIDTH) px = $urandom_range(0, SCREEN_WIDTH - 1);
                    if (py < 0 || py >= SCREEN_HEIGHT) py = $urandom_range(0, SCREEN_HEIGHT - 1);
                end
                queue_compose(px, py, $urandom);
            end
        end
    endtask

    // acceptance of input transactions and checking of results
    always @(posedge i_clk) begin
        blit_op_t      op;
        pixel_result_t exp_r;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("** scaled_alpha_blit: FAILED **");
            $finish;
        end
        if (i_rst_n && i_valid && o_ready) begin
            op.func = t_func'(i_func);
            op.index = i_texel_index;
            op.value = i_texel_value;
            op.px = i_pixel_x;
            op.py = i_pixel_y;
            op.dpix = i_dst_pixel;
            predict_blit(op);
            took_op = 1'b1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pixel_expect_q.size() == 0) begin
                $display("%0t unexpected result pixel %h covered %b",
                         $time, o_pixel_out, o_covered);
                err_count++;
            end else begin
                exp_r = pixel_expect_q.pop_front();
                if (o_pixel_out !== exp_r.pixel) begin
                    $display("%0t pixel_out expected %h actual %h",
                             $time, exp_r.pixel, o_pixel_out);
                    err_count++;
                end
                if (o_covered !== exp_r.covered) begin
                    $display("%0t covered expected %b actual %b",
                             $time, exp_r.covered, o_covered);
                    err_count++;
                end
            end
        end
    end

    // driver: one transaction at a time from the op queue
    always @(negedge i_clk) begin
        blit_op_t op;
        logic     next_valid;
        next_valid = i_valid;
        if (took_op || !i_valid) begin
            took_op = 1'b0;
            next_valid = 1'b0;
            if (send_idle > 0) begin
                send_idle--;
            end else if (!quiet_mode && $urandom_range(0, 15) == 0) begin
                send_idle = $urandom_range(1, 12);
            end else if (op_queue.size() != 0 && i_rst_n) begin
                op = op_queue.pop_front();
                i_func <= op.func;
                i_texel_index <= op.index;
                i_texel_value <= op.value;
                i_pixel_x <= op.px;
                i_pixel_y <= op.py;
                i_dst_pixel <= op.dpix;
                next_valid = 1'b1;
            end
        end
        i_valid <= next_valid;
        // receiver stalls
        if (recv_idle > 0) begin
            recv_idle--;
            i_ready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 15) == 0) begin
            recv_idle = $urandom_range(1, 12);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_func = FUNC_LOAD;
        i_texel_index = '0;
        i_texel_value = '0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        i_dst_pixel = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_DEST_X;
        i_cfg_data = '0;
        cur_dx = 0; cur_dy = 0; cur_dw = 0; cur_dh = 0;
        cur_sw = 0; cur_sh = 0; cur_flip = 1'b0;
        err_count = 0;
        cycle_count = 0;
        quiet_mode = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        took_op = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config draws nothing, index extremes, alpha cases
        queue_compose(0, 0, 32'hFFFF_FFFF);
        queue_compose(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 32'h0);
        queue_load(0, 32'h0000_0000);
        queue_load(TEXEL_DEPTH - 1, 32'hFFFF_FFFF);
        wait_idle();
        set_blit(10, 20, 8, 8, 4, 4, 0);
        queue_load(0, 32'h00AB_CDEF);
        queue_load(1, 32'hFF12_3456);
        queue_load(2, 32'h80FF_0080);
        queue_load(3, 32'h01FF_FFFF);
        queue_compose(10, 20, 32'h1234_5678);
        queue_compose(12, 20, 32'h0000_0000);
        queue_compose(14, 20, 32'hFFFF_FFFF);
        queue_compose(16, 20, 32'h00FF_00FF);
        queue_compose(9, 20, 32'hDEAD_BEEF);
        queue_compose(18, 27, 32'hCAFE_F00D);
        queue_compose(17, 28, 32'h0BAD_F00D);
        wait_idle();
        // flipped with empty source: row wraps to the top of memory
        set_blit(0, 0, 16, 16, 5, 0, 1);
        queue_compose(0, 0, 32'h1111_1111);
        queue_compose(15, 15, 32'h2222_2222);
        // negative origin, widest rectangle, 1024 by 1024 source
        wait_idle();
        set_blit(-1024, -1024, 1023, 1023, 1024, 1024, 0);
        queue_compose(0, 0, 32'h3333_3333);
        wait_idle();
        set_blit(-512, -800, 1023, 1023, 1024, 1024, 1);
        queue_compose(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 32'h4444_4444);
        queue_compose(0, 0, 32'h5555_5555);
        queue_compose(511, 200, 32'h6666_6666);
        wait_idle();
        set_blit(1023, 1023, 1023, 1023, 1, 1, 0);
        queue_compose(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 32'h7777_7777);
        wait_idle();

        // random phases, each with fresh settings
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) quiet_mode = 1'b1;
            set_blit($urandom_range(0, 560) - 40, $urandom_range(0, 260) - 20,
                     ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 600),
                     ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 260),
                     (ph == 4) ? 1024 : $urandom_range(0, 24),
                     (ph == 4) ? 1024 : $urandom_range(0, 24),
                     $urandom_range(0, 1));
            random_ops(60);
            // sender holds off until every result is back
            wait_idle();
            random_ops(60);
            wait_idle();
        end

        if (err_count == 0) begin
            $display("** scaled_alpha_blit: PASSED **");
        end else begin
            $display("** scaled_alpha_blit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sab_pkg.sv
rtl/core/sab_div.sv
rtl/core/scaled_alpha_blit.sv
bench/tb_scaled_alpha_blit.sv
